FILE: rtl/sat_pkg.sv
`default_nettype none

package sat_pkg;

  typedef enum logic [2:0] {
    KindByte      = 3'd0,
    KindOpenByte  = 3'd1,
    KindOpenNone  = 3'd2,
    KindWordEnd   = 3'd3,
    KindSeparator = 3'd4,
    KindStreamEnd = 3'd5
  } kind_e;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] data;
    logic       closes;
  } res_t;

  localparam logic [7:0] CharNul       = 8'h00;
  localparam logic [7:0] CharTab       = 8'h09;
  localparam logic [7:0] CharLf        = 8'h0a;
  localparam logic [7:0] CharCr        = 8'h0d;
  localparam logic [7:0] CharSpace     = 8'h20;
  localparam logic [7:0] CharDquote    = 8'h22;
  localparam logic [7:0] CharSquote    = 8'h27;
  localparam logic [7:0] CharBackslash = 8'h5c;
  localparam logic [7:0] CharLowerN    = 8'h6e;
  localparam logic [7:0] CharLowerR    = 8'h72;
  localparam logic [7:0] CharLowerT    = 8'h74;

endpackage

`default_nettype wire

FILE: rtl/sat_parser.sv
`default_nettype none

module sat_parser import sat_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       eoi_i,
  output res_t            res_o
);

  typedef enum logic [2:0] {
    ModeBetween = 3'd0,
    ModePlain   = 3'd1,
    ModeDouble  = 3'd2,
    ModeSingle  = 3'd3,
    ModeEnded   = 3'd4
  } mode_e;

  mode_e mode_q, mode_d;
  logic  esc_q, esc_d;
  mode_e own_mode;

  always_comb begin
    mode_d     = mode_q;
    esc_d      = esc_q;
    res_o      = '0;
    res_o.kind = KindByte;
    own_mode   = (byte_i == CharDquote) ? ModeDouble : ModeSingle;
    case (mode_q)
      ModeBetween, ModePlain, ModeDouble, ModeSingle: begin
        if (eoi_i || (byte_i == CharNul)) begin
          mode_d       = ModeEnded;
          esc_d        = 1'b0;
          res_o.valid  = 1'b1;
          res_o.kind   = KindStreamEnd;
          res_o.closes = (mode_q != ModeBetween);
        end else if (esc_q) begin
          esc_d       = 1'b0;
          res_o.valid = 1'b1;
          case (byte_i)
            CharLowerN: res_o.data = CharLf;
            CharLowerR: res_o.data = CharCr;
            CharLowerT: res_o.data = CharTab;
            default:    res_o.data = byte_i;
          endcase
        end else begin
          case (byte_i)
            CharBackslash: begin
              esc_d = 1'b1;
              if (mode_q == ModeBetween) begin
                mode_d      = ModePlain;
                res_o.valid = 1'b1;
                res_o.kind  = KindOpenNone;
              end
            end
            CharLf: begin
              res_o.valid = 1'b1;
              if (mode_q == ModeBetween || mode_q == ModePlain) begin
                mode_d       = ModeBetween;
                res_o.kind   = KindSeparator;
                res_o.closes = (mode_q == ModePlain);
              end else begin
                res_o.data = byte_i;
              end
            end
            CharSquote, CharDquote: begin
              if (mode_q == ModeBetween) begin
                mode_d      = own_mode;
                res_o.valid = 1'b1;
                res_o.kind  = KindOpenNone;
              end else if (mode_q == own_mode) begin
                mode_d = ModePlain;
              end else if (mode_q == ModePlain) begin
                mode_d = own_mode;
              end else begin
                res_o.valid = 1'b1;
                res_o.data  = byte_i;
              end
            end
            CharSpace, CharCr, CharTab: begin
              if (mode_q == ModePlain) begin
                mode_d      = ModeBetween;
                res_o.valid = 1'b1;
                res_o.kind  = KindWordEnd;
              end else if (mode_q != ModeBetween) begin
                res_o.valid = 1'b1;
                res_o.data  = byte_i;
              end
            end
            default: begin
              res_o.valid = 1'b1;
              res_o.data  = byte_i;
              if (mode_q == ModeBetween) begin
                mode_d     = ModePlain;
                res_o.kind = KindOpenByte;
              end
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeBetween;
      esc_q  <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      esc_q  <= esc_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/shell_argument_tokenizer_top.sv
// Shell word splitter: one script byte per input transfer, or an end mark.
// Input channel: in_valid_i / in_ready_o with in_byte_i and end_of_input_i.
// Output channel: out_valid_o / out_ready_i with kind_o, out_byte_o and
// closes_word_o. A byte yields zero or one result; blanks between words,
// a backslash inside a word and a quote that switches quoting yield none.
// Path: a byte is held in the input register, parsed, and its result is
// loaded into the result register (one input register, one result
// register); the parse mode is updated with the same step.
// Throughput: one byte per cycle while the receiver does not stall.
// Reset: mode returns to between words, escape flag clears, both
// registers empty. After a NUL byte or the end mark no further results
// come until reset, though bytes are still taken.
// Receiver stall: the result register holds; one more byte waits in the
// input register, after which in_ready_o drops until out_ready_i rises.
`default_nettype none

module shell_argument_tokenizer_top import sat_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       end_of_input_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [2:0]      kind_o,
  output logic [7:0]      out_byte_o,
  output logic            closes_word_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_eoi_q;
  logic       out_valid_q;
  kind_e      kind_q;
  logic [7:0] out_byte_q;
  logic       closes_q;
  logic       step;
  res_t       res;

  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  sat_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .eoi_i  (in_eoi_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (step) begin
        out_valid_q <= res.valid;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
      in_eoi_q  <= end_of_input_i;
    end
    if (step) begin
      kind_q     <= res.kind;
      out_byte_q <= res.data;
      closes_q   <= res.closes;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign out_byte_o    = out_byte_q;
  assign closes_word_o = closes_q;

endmodule

`default_nettype wire

FILE: sim/tb_shell_argument_tokenizer_top.sv
`timescale 1ns / 100ps

module tb_shell_argument_tokenizer_top;
  import sat_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumRows = 26;

  typedef enum logic [2:0] {
    ModeBetween = 3'd0,
    ModePlain   = 3'd1,
    ModeDouble  = 3'd2,
    ModeSingle  = 3'd3,
    ModeEnded   = 3'd4
  } parse_mode_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       closes;
  } token_t;

  typedef struct packed {
    logic [7:0] chr;
    logic       typed;
    kind_e      kind;
    logic [7:0] data;
    logic       closes;
  } script_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       end_mark = 1'b0;
  logic       out_ready = 1'b0;

  wire logic       in_ready;
  wire logic       out_valid;
  wire logic [2:0] kind;
  wire logic [7:0] out_byte;
  wire logic       closes_word;

  parse_mode_e mode = ModeBetween;
  logic        escape_armed = 1'b0;
  token_t      expected_tokens[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;

  shell_argument_tokenizer_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .in_byte_i      (in_byte),
    .end_of_input_i (end_mark),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .kind_o         (kind),
    .out_byte_o     (out_byte),
    .closes_word_o  (closes_word)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic tokenize_byte(input logic [7:0] chr, input logic eoi,
                                         output token_t tok);
    logic [7:0]  c;
    parse_mode_e m;
    parse_mode_e own;
    c = chr;
    m = mode;
    tok = '{KindByte, 8'h00, 1'b0};
    if (m == ModeEnded) return 1'b0;
    if (eoi || c == CharNul) begin
      mode = ModeEnded;
      escape_armed = 1'b0;
      tok.kind = KindStreamEnd;
      tok.closes = (m != ModeBetween);
      return 1'b1;
    end
    if (escape_armed) begin
      escape_armed = 1'b0;
      if (c == CharLowerN) c = CharLf;
      else if (c == CharLowerR) c = CharCr;
      else if (c == CharLowerT) c = CharTab;
      tok.data = c;
      return 1'b1;
    end
    case (c)
      CharBackslash: begin
        escape_armed = 1'b1;
        if (m == ModeBetween) begin
          mode = ModePlain;
          tok.kind = KindOpenNone;
          return 1'b1;
        end
        return 1'b0;
      end
      CharLf: begin
        if (m == ModeBetween || m == ModePlain) begin
          mode = ModeBetween;
          tok.kind = KindSeparator;
          tok.closes = (m == ModePlain);
          return 1'b1;
        end
      end
      CharDquote, CharSquote: begin
        own = (c == CharDquote) ? ModeDouble : ModeSingle;
        if (m == ModeBetween) begin
          mode = own;
          tok.kind = KindOpenNone;
          return 1'b1;
        end
        if (m == own) begin
          mode = ModePlain;
          return 1'b0;
        end
        if (m == ModePlain) begin
          mode = own;
          return 1'b0;
        end
      end
      CharSpace, CharCr, CharTab: begin
        if (m == ModePlain) begin
          mode = ModeBetween;
          tok.kind = KindWordEnd;
          return 1'b1;
        end
        if (m == ModeBetween) return 1'b0;
      end
      default: begin
        if (m == ModeBetween) begin
          mode = ModePlain;
          tok.kind = KindOpenByte;
          tok.data = c;
          return 1'b1;
        end
      end
    endcase
    tok.data = c;
    return 1'b1;
  endfunction

  function automatic logic [7:0] random_script_byte();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return 8'h61 + 8'($urandom_range(0, 25));
    if (sel < 50) begin
      case ($urandom_range(0, 2))
        0: return CharSpace;
        1: return CharTab;
        default: return CharCr;
      endcase
    end
    if (sel < 57) return CharLf;
    if (sel < 64) return CharDquote;
    if (sel < 70) return CharSquote;
    if (sel < 78) return CharBackslash;
    if (sel < 84) begin
      case ($urandom_range(0, 2))
        0: return CharLowerN;
        1: return CharLowerR;
        default: return CharLowerT;
      endcase
    end
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  task automatic send_item(input logic [7:0] chr, input logic eoi, input logic typed,
                           input token_t typed_tok);
    token_t tok;
    logic   hit;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= chr;
    end_mark <= eoi;
    do @(posedge clk); while (!in_ready);
    hit = tokenize_byte(chr, eoi, tok);
    if (typed) expected_tokens.push_back(typed_tok);
    else if (hit) expected_tokens.push_back(tok);
  endtask

  always @(posedge clk) begin
    token_t want;
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
    if (rst_n && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        note_mismatch($sformatf("unexpected transfer: kind %0d byte %02h closes %0b",
                                kind, out_byte, closes_word));
      end else begin
        want = expected_tokens.pop_front();
        if (kind !== want.kind || out_byte !== want.data || closes_word !== want.closes)
          note_mismatch($sformatf(
              "mismatch: expected kind %0d byte %02h closes %0b, got %0d %02h %0b",
              want.kind, want.data, want.closes, kind, out_byte, closes_word));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("shell_argument_tokenizer_top test failed");
      $finish;
    end
  end

  initial begin
    script_row_t rows [NumRows];
    token_t      none;
    none = '{KindByte, 8'h00, 1'b0};
    rows = '{
      '{8'h61,         1'b1, KindOpenByte,  8'h61,  1'b0},
      '{8'hff,         1'b1, KindByte,      8'hff,  1'b0},
      '{CharSpace,     1'b1, KindWordEnd,   8'h00,  1'b0},
      '{CharSpace,     1'b0, KindByte,      8'h00,  1'b0},
      '{CharTab,       1'b0, KindByte,      8'h00,  1'b0},
      '{CharDquote,    1'b1, KindOpenNone,  8'h00,  1'b0},
      '{CharSquote,    1'b0, KindByte,      8'h00,  1'b0},
      '{CharLf,        1'b0, KindByte,      8'h00,  1'b0},
      '{CharBackslash, 1'b0, KindByte,      8'h00,  1'b0},
      '{CharLowerN,    1'b1, KindByte,      CharLf, 1'b0},
      '{CharDquote,    1'b0, KindByte,      8'h00,  1'b0},
      '{CharSquote,    1'b0, KindByte,      8'h00,  1'b0},
      '{CharDquote,    1'b0, KindByte,      8'h00,  1'b0},
      '{CharBackslash, 1'b0, KindByte,      8'h00,  1'b0},
      '{CharSquote,    1'b0, KindByte,      8'h00,  1'b0},
      '{CharSquote,    1'b0, KindByte,      8'h00,  1'b0},
      '{CharLf,        1'b1, KindSeparator, 8'h00,  1'b1},
      '{CharLf,        1'b1, KindSeparator, 8'h00,  1'b0},
      '{CharBackslash, 1'b1, KindOpenNone,  8'h00,  1'b0},
      '{CharLowerT,    1'b0, KindByte,      8'h00,  1'b0},
      '{CharBackslash, 1'b0, KindByte,      8'h00,  1'b0},
      '{CharLowerR,    1'b0, KindByte,      8'h00,  1'b0},
      '{CharCr,        1'b1, KindWordEnd,   8'h00,  1'b0},
      '{8'h01,         1'b1, KindOpenByte,  8'h01,  1'b0},
      '{CharBackslash, 1'b0, KindByte,      8'h00,  1'b0},
      '{8'h80,         1'b0, KindByte,      8'h00,  1'b0}
    };
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_idle = 24;
    recv_idle = 84;
    for (int i = 0; i < NumRows; i++)
      send_item(rows[i].chr, 1'b0, rows[i].typed,
                '{rows[i].kind, rows[i].data, rows[i].closes});
    repeat (280) send_item(random_script_byte(), 1'b0, 1'b0, none);

    send_idle = 84;
    recv_idle = 24;
    repeat (300) send_item(random_script_byte(), 1'b0, 1'b0, none);

    send_idle = 0;
    recv_idle = 0;
    repeat (300) send_item(random_script_byte(), 1'b0, 1'b0, none);

    // end mark closes the stream; everything after it must stay silent
    send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, none);
    send_item(CharNul, 1'b0, 1'b0, none);
    send_item(8'h61, 1'b0, 1'b0, none);
    send_item(CharLf, 1'b0, 1'b0, none);
    send_item(8'hff, 1'b1, 1'b0, none);
    send_item(CharBackslash, 1'b0, 1'b0, none);
    in_valid <= 1'b0;

    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("shell_argument_tokenizer_top test passed");
    end else begin
      $display("shell_argument_tokenizer_top test failed");
    end
    $finish;
  end

endmodule

FILE: shell_argument_tokenizer_top.f
rtl/sat_pkg.sv
rtl/sat_parser.sv
rtl/shell_argument_tokenizer_top.sv
sim/tb_shell_argument_tokenizer_top.sv
